// ----- hw/rtl/mcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mcr_pkg;

    // Item kinds carried on the slave tuser bit
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Per-job flags handed from the front end to the point emitter
    typedef struct packed {
        logic single;   // zero-radius start: emit the center once
        logic swap;     // x != y: emit the four swapped octant points too
        logic done;     // this step completes the circle
    } t_job_ctl;

    localparam int JOB_CTL_BITS = $bits(t_job_ctl);

endpackage
`default_nettype wire

// ----- hw/rtl/mcr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mcr_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic                    i_kind,
    input  wire logic [COORD_BITS-1:0]   i_center_x,
    input  wire logic [COORD_BITS-1:0]   i_center_y,
    input  wire logic [COORD_BITS-1:0]   i_radius,
    input  wire logic                    i_q_full,
    output logic                         o_ready,
    output logic                         o_push,
    output logic [COORD_BITS-1:0]        o_cx,
    output logic [COORD_BITS-1:0]        o_cy,
    output logic [COORD_BITS:0]          o_x,
    output logic [COORD_BITS:0]          o_y,
    output mcr_pkg::t_job_ctl            o_ctl
);

    localparam int WW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 4;

    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [WW-1:0]         r_x, r_y;
    logic signed [EW-1:0]  r_err;
    logic                  r_active;

    logic [COORD_BITS-1:0] n_cx, n_cy;
    logic [WW-1:0]         n_x, n_y;
    logic signed [EW-1:0]  n_err;
    logic                  n_active;

    logic                  accept;
    logic                  is_start;
    logic                  step_y;
    logic [WW-1:0]         adv_x, adv_y;
    logic signed [EW-1:0]  adv_err;
    logic                  adv_done;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign is_start = (i_kind == mcr_pkg::KIND_START);

    // Midpoint decision: y moves when the error is not positive, else x moves
    assign step_y  = (r_err <= 0);
    assign adv_y   = step_y ? r_y + WW'(1) : r_y;
    assign adv_x   = step_y ? r_x : r_x - WW'(1);
    assign adv_err = step_y ? r_err + EW'({r_y, 1'b1}) + EW'(2)
                            : r_err - EW'({r_x, 1'b1}) + EW'(2);
    assign adv_done = (adv_x < adv_y);

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        n_active = r_active;
        o_push   = 1'b0;
        o_cx     = r_cx;
        o_cy     = r_cy;
        o_x      = r_x;
        o_y      = r_y;
        o_ctl    = '{single: 1'b0, swap: (r_x != r_y), done: adv_done};
        if (accept) begin
            if (is_start) begin
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_x      = WW'(i_radius);
                n_y      = '0;
                n_err    = '0;
                n_active = 1'b1;
                o_push   = (i_radius == '0);
                o_cx     = i_center_x;
                o_cy     = i_center_y;
                o_x      = '0;
                o_y      = '0;
                o_ctl    = '{single: 1'b1, swap: 1'b0, done: 1'b0};
            end else if (r_active) begin
                n_x      = adv_x;
                n_y      = adv_y;
                n_err    = adv_err;
                n_active = !adv_done;
                o_push   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_err    <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_err    <= n_err;
            r_active <= n_active;
        end
    end

    a_active_in_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_y <= r_x))
        else $error("walk left the octant while a circle is active");

endmodule
`default_nettype wire

// ----- hw/rtl/mcr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mcr_queue #(
    parameter int WIDTH = 54
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue popped while empty");

endmodule
`default_nettype wire

// ----- hw/rtl/mcr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mcr_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_empty,
    input  wire logic [COORD_BITS-1:0]   i_cx,
    input  wire logic [COORD_BITS-1:0]   i_cy,
    input  wire logic [COORD_BITS:0]     i_x,
    input  wire logic [COORD_BITS:0]     i_y,
    input  wire mcr_pkg::t_job_ctl       i_ctl,
    output logic                         o_pop,
    input  wire logic                    i_tready,
    output logic                         o_tvalid,
    output logic signed [COORD_BITS+1:0] o_point_x,
    output logic signed [COORD_BITS+1:0] o_point_y,
    output logic                         o_last,
    output logic                         o_finished
);

    localparam int PW = COORD_BITS + 2;
    localparam logic [2:0] LAST_SINGLE = 3'd0;
    localparam logic [2:0] LAST_AXIS   = 3'd3;
    localparam logic [2:0] LAST_FULL   = 3'd7;

    logic [2:0]           r_idx;
    logic                 r_valid;
    logic signed [PW-1:0] r_px, r_py;
    logic                 r_last, r_fin;

    logic                 load;
    logic [2:0]           last_idx;
    logic                 at_last;
    logic signed [PW-1:0] off_a, off_b, pt_x, pt_y;

    assign load     = !i_q_empty && (!r_valid || i_tready);
    assign last_idx = i_ctl.single ? LAST_SINGLE : (i_ctl.swap ? LAST_FULL : LAST_AXIS);
    assign at_last  = (r_idx == last_idx);
    assign o_pop    = load && at_last;

    // Index bit 2 swaps x and y, bit 0 negates the column offset, bit 1 the row offset
    assign off_a = r_idx[2] ? PW'(i_y) : PW'(i_x);
    assign off_b = r_idx[2] ? PW'(i_x) : PW'(i_y);
    assign pt_x  = r_idx[0] ? PW'(i_cx) - off_a : PW'(i_cx) + off_a;
    assign pt_y  = r_idx[1] ? PW'(i_cy) - off_b : PW'(i_cy) + off_b;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= pt_x;
            r_py   <= pt_y;
            r_last <= at_last;
            r_fin  <= i_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_last ? 3'd0 : r_idx + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid   = r_valid;
    assign o_point_x  = r_px;
    assign o_point_y  = r_py;
    assign o_last     = r_last;
    assign o_finished = r_fin;

    a_idx_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> !i_q_empty)
        else $error("point index advanced without a job at the queue head");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx <= last_idx))
        else $error("point index beyond the job's point count");

endmodule
`default_nettype wire

// ----- hw/rtl/midpoint_circle_rasterizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  tdata (low bit up)                        tuser      tlast
// s_axis    in         center_x, center_y, radius, zero pad       kind       -
// m_axis    out        point_x, point_y, zero pad                 finished   last
//
// A step item yields 8 points (4 when x == y), one per cycle from the point
// emitter while m_axis tready is high; a start yields 0 or 1 point.
// The front end updates the walk on acceptance and queues a job (2 deep);
// input stalls only when that queue is full.
// Output is registered; m_axis tready low holds the point and the queue.
// Reset (i_rst_n low, synchronous) drops any circle and pending points.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata, // center_x, center_y, radius
    input  wire logic                   i_s_axis_tuser,  // kind
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata, // point_x, point_y
    output logic                        o_m_axis_tuser,  // finished
    output logic                        o_m_axis_tlast   // last
);

    localparam int CW = COORD_BITS;
    localparam int PW = COORD_BITS + 2;
    localparam int JW = 2 * CW + 2 * (CW + 1) + mcr_pkg::JOB_CTL_BITS;

    logic                  q_full, q_empty, push, pop;
    logic [CW-1:0]         f_cx, f_cy, b_cx, b_cy;
    logic [CW:0]           f_x, f_y, b_x, b_y;
    mcr_pkg::t_job_ctl     f_ctl, b_ctl;
    logic [JW-1:0]         q_in, q_out;
    logic signed [PW-1:0]  point_x, point_y;

    mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_center_x (i_s_axis_tdata[CW-1:0]),
        .i_center_y (i_s_axis_tdata[2*CW-1:CW]),
        .i_radius   (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_q_full   (q_full),
        .o_ready    (o_s_axis_tready),
        .o_push     (push),
        .o_cx       (f_cx),
        .o_cy       (f_cy),
        .o_x        (f_x),
        .o_y        (f_y),
        .o_ctl      (f_ctl)
    );

    assign q_in = {f_ctl, f_y, f_x, f_cy, f_cx};

    mcr_queue #(.WIDTH(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_y, b_x, b_cy, b_cx} = q_out;

    mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cx       (b_cx),
        .i_cy       (b_cy),
        .i_x        (b_x),
        .i_y        (b_y),
        .i_ctl      (b_ctl),
        .o_pop      (pop),
        .i_tready   (i_m_axis_tready),
        .o_tvalid   (o_m_axis_tvalid),
        .o_point_x  (point_x),
        .o_point_y  (point_y),
        .o_last     (o_m_axis_tlast),
        .o_finished (o_m_axis_tuser)
    );

    always_comb begin
        o_m_axis_tdata             = '0;
        o_m_axis_tdata[PW-1:0]     = point_x;
        o_m_axis_tdata[2*PW-1:PW]  = point_y;
    end

endmodule
`default_nettype wire
